// File: rtl/core/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: rtl/core/lppa_pkg.sv
`default_nettype none
package lppa_pkg;

   // field widths
   localparam int SAMPLE_W   = 16;
   localparam int THRESH_W   = 15;
   localparam int PAIR_W     = 20;
   localparam int AVG_W      = 16;
   localparam int SUM_W      = 36;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   // pending peak queue
   localparam int QUEUE_DEPTH = 64;
   localparam int QADDR_W     = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // pair count saturation point
   localparam logic [PAIR_W-1:0] PAIR_CAP = PAIR_W'(1) << (PAIR_W - 1);

   // divider step counter
   localparam int STEP_W = $clog2(SUM_W + 1);

   // lobe sign codes
   localparam logic [1:0] LOBE_NONE = 2'd0;
   localparam logic [1:0] LOBE_POS  = 2'd1;
   localparam logic [1:0] LOBE_NEG  = 2'd2;

   // register index of the threshold
   localparam logic [CSR_ADDR_W-3:0] REG_THRESH = '0;

   typedef struct packed {
      logic              start;
      logic [SUM_W-1:0]  dividend;
      logic [PAIR_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [SUM_W-1:0] quotient;
   } div_rsp_type;

endpackage
`default_nettype wire

// File: rtl/core/lppa_req_if.sv
`default_nettype none
interface lppa_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [lppa_pkg::SAMPLE_W-1:0] sample;
   logic                                last;

   modport source (output valid, output sample, output last, input ready);
   modport sink (input valid, input sample, input last, output ready);
endinterface
`default_nettype wire

// File: rtl/core/lppa_rsp_if.sv
`default_nettype none
interface lppa_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [lppa_pkg::AVG_W-1:0]     avg_amplitude;
   logic [lppa_pkg::PAIR_W-1:0]    pairs_found;
   logic                           queue_overflow;

   modport source (output valid, output avg_amplitude, output pairs_found,
                   output queue_overflow, input ready);
   modport sink (input valid, input avg_amplitude, input pairs_found,
                 input queue_overflow, output ready);
endinterface
`default_nettype wire

// File: rtl/core/lppa_ram.sv
`default_nettype none
module lppa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // single write port, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

// File: rtl/core/lppa_div.sv
`default_nettype none
module lppa_div (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire lppa_pkg::div_req_type div_req,
   output      lppa_pkg::div_rsp_type div_rsp
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [lppa_pkg::STEP_W-1:0]   step_ff, step_in;
   logic [lppa_pkg::PAIR_W:0]     rem_ff, rem_in;
   logic [lppa_pkg::SUM_W-1:0]    quot_ff, quot_in;
   logic [lppa_pkg::PAIR_W-1:0]   dvs_ff, dvs_in;
   logic [lppa_pkg::PAIR_W:0]     shifted;
   logic [lppa_pkg::PAIR_W:0]     diff;

   // one restoring step per cycle: shift in a dividend bit, trial subtract
   assign shifted = {rem_ff[lppa_pkg::PAIR_W-1:0], quot_ff[lppa_pkg::SUM_W-1]};
   assign diff    = shifted - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      dvs_in  = dvs_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         step_in = lppa_pkg::STEP_W'(lppa_pkg::SUM_W);
         rem_in  = '0;
         quot_in = div_req.dividend;
         dvs_in  = div_req.divisor;
      end else if (busy_ff) begin
         if (diff[lppa_pkg::PAIR_W]) begin
            rem_in  = shifted;
            quot_in = {quot_ff[lppa_pkg::SUM_W-2:0], 1'b0};
         end else begin
            rem_in  = diff;
            quot_in = {quot_ff[lppa_pkg::SUM_W-2:0], 1'b1};
         end
         step_in = step_ff - 1'b1;
         if (step_ff == lppa_pkg::STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      dvs_ff  <= dvs_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quot_ff;

endmodule
`default_nettype wire

// File: rtl/core/lobe_peak_to_peak_amplitude.sv
// a sample passes S_LAST back to S_IDLE; one closing a kept lobe peak is queued in
//   S_OFFER or pairs with the queue head in S_PAIR (registered head read, then sum add)
// the last sample then closes its own lobe, runs a 36-step serial divider and the result
//   load, which waits while the previous result still waits on the output
// throughput: one sample at a time; ready is high only while the sequencer is idle
// reset: synchronous, active high; clears sequencer, lobe, queue pointers, sums, threshold
`default_nettype none
`include "assert_macros.svh"
module lobe_peak_to_peak_amplitude (
   input  wire logic                               clock,
   input  wire logic                               reset,
   lppa_req_if.sink                                req_bus,
   lppa_rsp_if.source                              rsp_bus,
   input  wire logic                               psel,
   input  wire logic                               penable,
   input  wire logic                               pwrite,
   input  wire logic [lppa_pkg::CSR_ADDR_W-1:0]    paddr,
   input  wire logic [lppa_pkg::CSR_DATA_W-1:0]    pwdata,
   output      logic [lppa_pkg::CSR_DATA_W-1:0]    prdata,
   output      logic                               pready
);

   // sequencer codes
   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_OFFER    = 3'd1;
   localparam logic [2:0] S_PAIR     = 3'd2;
   localparam logic [2:0] S_LAST     = 3'd3;
   localparam logic [2:0] S_DIV_WAIT = 3'd4;
   localparam logic [2:0] S_EMIT     = 3'd5;

   localparam int SW = lppa_pkg::SAMPLE_W;

   logic [2:0]                       state_ff, state_in;
   logic [lppa_pkg::THRESH_W-1:0]    thresh_ff, thresh_in;
   logic [1:0]                       lobe_sign_ff, lobe_sign_in;
   logic signed [SW-1:0]             lobe_peak_ff, lobe_peak_in;
   logic                             pend_sign_ff, pend_sign_in;
   logic [lppa_pkg::QCNT_W-1:0]      pend_count_ff, pend_count_in;
   logic [lppa_pkg::QADDR_W-1:0]     pend_head_ff, pend_head_in;
   logic [lppa_pkg::SUM_W-1:0]       amp_sum_ff, amp_sum_in;
   logic [lppa_pkg::PAIR_W-1:0]      pair_total_ff, pair_total_in;
   logic                             overflow_ff, overflow_in;
   logic                             last_ff, last_in;
   logic                             div_pend_ff, div_pend_in;
   logic                             close_min_ff, close_min_in;
   logic signed [SW-1:0]             close_peak_ff, close_peak_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [lppa_pkg::AVG_W-1:0]       rsp_avg_ff, rsp_avg_in;
   logic [lppa_pkg::PAIR_W-1:0]      rsp_pairs_ff, rsp_pairs_in;
   logic                             rsp_ovf_ff, rsp_ovf_in;

   logic                             accept;
   logic                             thresh_wr;
   logic                             kept;
   logic signed [SW:0]               peak_ext;
   logic signed [SW:0]               peak_mag_neg;
   logic signed [SW:0]               thresh_ext;
   logic                             samp_pos;
   logic                             samp_neg;
   logic                             samp_closes;
   logic [lppa_pkg::QCNT_W:0]        tail_sum;
   logic [lppa_pkg::QADDR_W-1:0]     tail_addr;
   logic                             q_wr_en;
   logic [SW-1:0]                    q_rd_data;
   logic signed [SW:0]               amp_wide;
   logic [lppa_pkg::AVG_W-1:0]       amp;
   lppa_pkg::div_req_type            div_req;
   lppa_pkg::div_rsp_type            div_rsp;

   // handshakes
   assign accept        = req_bus.valid && req_bus.ready;
   assign req_bus.ready = (state_ff == S_IDLE);
   assign pready        = 1'b1;
   assign thresh_wr     = psel && penable && pwrite
                          && (paddr[lppa_pkg::CSR_ADDR_W-1:2] == lppa_pkg::REG_THRESH);

   // register read back
   always_comb begin
      prdata = '0;
      if (paddr[lppa_pkg::CSR_ADDR_W-1:2] == lppa_pkg::REG_THRESH) begin
         prdata = {{(lppa_pkg::CSR_DATA_W - lppa_pkg::THRESH_W){1'b0}}, thresh_ff};
      end
   end

   // threshold test on the open lobe
   assign peak_ext     = {lobe_peak_ff[SW-1], lobe_peak_ff};
   assign peak_mag_neg = -peak_ext;
   assign thresh_ext   = {{(SW + 1 - lppa_pkg::THRESH_W){1'b0}}, thresh_ff};
   assign kept = ((lobe_sign_ff == lppa_pkg::LOBE_POS) && (peak_ext > thresh_ext))
              || ((lobe_sign_ff == lppa_pkg::LOBE_NEG) && (peak_mag_neg > thresh_ext));

   // sample classification
   assign samp_neg    = req_bus.sample[SW-1];
   assign samp_pos    = !samp_neg && (req_bus.sample != '0);
   assign samp_closes = (samp_pos && (lobe_sign_ff != lppa_pkg::LOBE_POS))
                     || (samp_neg && (lobe_sign_ff != lppa_pkg::LOBE_NEG))
                     || (!samp_pos && !samp_neg);

   // queue tail position, wrapped
   always_comb begin
      tail_sum = {{(lppa_pkg::QCNT_W + 1 - lppa_pkg::QADDR_W){1'b0}}, pend_head_ff}
               + {1'b0, pend_count_ff};
      if (tail_sum >= (lppa_pkg::QCNT_W + 1)'(lppa_pkg::QUEUE_DEPTH)) begin
         tail_sum = tail_sum - (lppa_pkg::QCNT_W + 1)'(lppa_pkg::QUEUE_DEPTH);
      end
      tail_addr = tail_sum[lppa_pkg::QADDR_W-1:0];
   end

   // pair amplitude from the queue head
   assign amp_wide = close_min_ff
                   ? ($signed({q_rd_data[SW-1], q_rd_data}) - {close_peak_ff[SW-1], close_peak_ff})
                   : ({close_peak_ff[SW-1], close_peak_ff} - $signed({q_rd_data[SW-1], q_rd_data}));
   assign amp      = amp_wide[lppa_pkg::AVG_W-1:0];

   assign q_wr_en = (state_ff == S_OFFER)
                 && !((pend_count_ff != '0) && (pend_sign_ff != close_min_ff))
                 && (pend_count_ff < lppa_pkg::QCNT_W'(lppa_pkg::QUEUE_DEPTH));

   // sequencer and datapath next state
   always_comb begin
      state_in      = state_ff;
      thresh_in     = thresh_ff;
      lobe_sign_in  = lobe_sign_ff;
      lobe_peak_in  = lobe_peak_ff;
      pend_sign_in  = pend_sign_ff;
      pend_count_in = pend_count_ff;
      pend_head_in  = pend_head_ff;
      amp_sum_in    = amp_sum_ff;
      pair_total_in = pair_total_ff;
      overflow_in   = overflow_ff;
      last_in       = last_ff;
      div_pend_in   = div_pend_ff;
      close_min_in  = close_min_ff;
      close_peak_in = close_peak_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_avg_in    = rsp_avg_ff;
      rsp_pairs_in  = rsp_pairs_ff;
      rsp_ovf_in    = rsp_ovf_ff;
      div_req.start    = 1'b0;
      div_req.dividend = amp_sum_ff;
      div_req.divisor  = pair_total_ff;

      if (thresh_wr) begin
         thresh_in = pwdata[lppa_pkg::THRESH_W-1:0];
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               last_in       = req_bus.last;
               close_min_in  = (lobe_sign_ff == lppa_pkg::LOBE_NEG);
               close_peak_in = lobe_peak_ff;
               if (samp_pos) begin
                  lobe_sign_in = lppa_pkg::LOBE_POS;
                  if (samp_closes || (req_bus.sample >= lobe_peak_ff)) begin
                     lobe_peak_in = req_bus.sample;
                  end
               end else if (samp_neg) begin
                  lobe_sign_in = lppa_pkg::LOBE_NEG;
                  if (samp_closes || (req_bus.sample <= lobe_peak_ff)) begin
                     lobe_peak_in = req_bus.sample;
                  end
               end else begin
                  lobe_sign_in = lppa_pkg::LOBE_NONE;
                  lobe_peak_in = '0;
               end
               state_in = (samp_closes && kept) ? S_OFFER : S_LAST;
            end
         end
         S_OFFER: begin
            if ((pend_count_ff != '0) && (pend_sign_ff != close_min_ff)) begin
               // head read is in flight this cycle
               state_in = S_PAIR;
            end else if (q_wr_en) begin
               pend_sign_in  = close_min_ff;
               pend_count_in = pend_count_ff + 1'b1;
               state_in      = S_LAST;
            end else begin
               overflow_in = 1'b1;
               state_in    = S_LAST;
            end
         end
         S_PAIR: begin
            pend_head_in  = (pend_head_ff == lppa_pkg::QADDR_W'(lppa_pkg::QUEUE_DEPTH - 1))
                          ? '0 : pend_head_ff + 1'b1;
            pend_count_in = pend_count_ff - 1'b1;
            if (pair_total_ff < lppa_pkg::PAIR_CAP) begin
               amp_sum_in    = amp_sum_ff
                             + {{(lppa_pkg::SUM_W - lppa_pkg::AVG_W){1'b0}}, amp};
               pair_total_in = pair_total_ff + 1'b1;
            end else begin
               overflow_in = 1'b1;
            end
            state_in = S_LAST;
         end
         S_LAST: begin
            if (last_ff) begin
               // end of record closes the open lobe
               last_in       = 1'b0;
               div_pend_in   = 1'b1;
               close_min_in  = (lobe_sign_ff == lppa_pkg::LOBE_NEG);
               close_peak_in = lobe_peak_ff;
               lobe_sign_in  = lppa_pkg::LOBE_NONE;
               lobe_peak_in  = '0;
               state_in      = kept ? S_OFFER : S_LAST;
            end else if (div_pend_ff) begin
               div_pend_in   = 1'b0;
               div_req.start = 1'b1;
               state_in      = S_DIV_WAIT;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_DIV_WAIT: begin
            if (div_rsp.done) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_avg_in    = (pair_total_ff == '0)
                             ? '0 : div_rsp.quotient[lppa_pkg::AVG_W-1:0];
               rsp_pairs_in  = pair_total_ff;
               rsp_ovf_in    = overflow_ff;
               // record done, clear the per-record state
               pend_sign_in  = 1'b0;
               pend_count_in = '0;
               pend_head_in  = '0;
               amp_sum_in    = '0;
               pair_total_in = '0;
               overflow_in   = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         thresh_ff     <= '0;
         lobe_sign_ff  <= lppa_pkg::LOBE_NONE;
         lobe_peak_ff  <= '0;
         pend_sign_ff  <= 1'b0;
         pend_count_ff <= '0;
         pend_head_ff  <= '0;
         amp_sum_ff    <= '0;
         pair_total_ff <= '0;
         overflow_ff   <= 1'b0;
         last_ff       <= 1'b0;
         div_pend_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         thresh_ff     <= thresh_in;
         lobe_sign_ff  <= lobe_sign_in;
         lobe_peak_ff  <= lobe_peak_in;
         pend_sign_ff  <= pend_sign_in;
         pend_count_ff <= pend_count_in;
         pend_head_ff  <= pend_head_in;
         amp_sum_ff    <= amp_sum_in;
         pair_total_ff <= pair_total_in;
         overflow_ff   <= overflow_in;
         last_ff       <= last_in;
         div_pend_ff   <= div_pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      close_min_ff  <= close_min_in;
      close_peak_ff <= close_peak_in;
      rsp_avg_ff    <= rsp_avg_in;
      rsp_pairs_ff  <= rsp_pairs_in;
      rsp_ovf_ff    <= rsp_ovf_in;
   end

   // pending peak queue
   lppa_ram #(
      .WIDTH (SW),
      .DEPTH (lppa_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .wr_en   (q_wr_en),
      .wr_addr (tail_addr),
      .wr_data (close_peak_ff),
      .rd_addr (pend_head_ff),
      .rd_data (q_rd_data)
   );

   // serial divider for the mean
   lppa_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.avg_amplitude  = rsp_avg_ff;
   assign rsp_bus.pairs_found    = rsp_pairs_ff;
   assign rsp_bus.queue_overflow = rsp_ovf_ff;

   // checks
   `ASSERT_SAME(a_pair_cap, clock, reset, 1'b1, pair_total_ff <= lppa_pkg::PAIR_CAP)
   `ASSERT_SAME(a_queue_fill, clock, reset, 1'b1,
                pend_count_ff <= lppa_pkg::QCNT_W'(lppa_pkg::QUEUE_DEPTH))
   `ASSERT_SAME(a_pair_needs_entry, clock, reset, state_ff == S_PAIR, pend_count_ff != '0)
   `ASSERT_NEXT(a_busy_after_accept, clock, reset, accept, !req_bus.ready)

endmodule
`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 100ps
module tb_top;

   localparam int HALF_PERIOD         = 6;
   localparam int RESET_CYCLES        = 2;
   // covers the last-sample lobe close plus the serial divider
   localparam int SETTLE_CYCLES       = 60;
   localparam int DRAIN_LIMIT         = 20000;
   localparam int HOLD_CYCLES         = 600;
   localparam int RANDOM_ITEMS        = 480;
   localparam int MIN_RECORDS         = 12;
   localparam int RECORDS_PER_SETTING = 6;
   localparam int MAX_REPORTS         = 10;

   typedef logic signed [lppa_pkg::SAMPLE_W-1:0] sample_type;

   typedef struct {
      logic [lppa_pkg::AVG_W-1:0]  avg;
      logic [lppa_pkg::PAIR_W-1:0] pairs;
      logic                        overflow;
   } amp_result_type;

   // tracks lobes and peak pairing of the open record, queues expected amplitudes
   class lobe_amp_tracker;
      amp_result_type                expected_amplitudes[$];
      int                            errors;
      int                            reported;
      logic [lppa_pkg::THRESH_W-1:0] threshold;
      logic [1:0]                    lobe_sign;
      sample_type                    lobe_peak;
      bit                            fifo_holds_min;
      sample_type                    peak_fifo[$];
      logic [lppa_pkg::SUM_W-1:0]    amp_sum;
      logic [lppa_pkg::PAIR_W-1:0]   pair_total;
      bit                            overflow;

      function new();
         threshold = '0;
         errors    = 0;
         reported  = 0;
         clear_record();
      endfunction

      function void clear_record();
         lobe_sign      = lppa_pkg::LOBE_NONE;
         lobe_peak      = '0;
         fifo_holds_min = 1'b0;
         peak_fifo.delete();
         amp_sum        = '0;
         pair_total     = '0;
         overflow       = 1'b0;
      endfunction

      function void set_threshold(logic [lppa_pkg::CSR_DATA_W-1:0] value);
         threshold = value[lppa_pkg::THRESH_W-1:0];
      endfunction

      // pair with the oldest opposite peak, else queue it
      function void offer_peak(bit is_min, sample_type peak);
         int other;
         int amp;
         if (peak_fifo.size() != 0 && fifo_holds_min != is_min) begin
            other = peak_fifo.pop_front();
            amp = is_min ? (other - int'(peak)) : (int'(peak) - other);
            if (pair_total < lppa_pkg::PAIR_CAP) begin
               amp_sum    = amp_sum + lppa_pkg::SUM_W'(amp);
               pair_total = pair_total + 1'b1;
            end else begin
               overflow = 1'b1;
            end
         end else if (peak_fifo.size() < lppa_pkg::QUEUE_DEPTH) begin
            fifo_holds_min = is_min;
            peak_fifo.insert(peak_fifo.size(), peak);
         end else begin
            overflow = 1'b1;
         end
      endfunction

      // keep the lobe peak only if its magnitude beats the threshold
      function void close_lobe();
         int thr;
         thr = int'(threshold);
         if (lobe_sign == lppa_pkg::LOBE_POS) begin
            if (int'(lobe_peak) > thr) offer_peak(1'b0, lobe_peak);
         end else if (lobe_sign == lppa_pkg::LOBE_NEG) begin
            if (-int'(lobe_peak) > thr) offer_peak(1'b1, lobe_peak);
         end
         lobe_sign = lppa_pkg::LOBE_NONE;
         lobe_peak = '0;
      endfunction

      // one accepted sample
      function void take_sample(sample_type s, logic last);
         amp_result_type r;
         if (s > 0) begin
            if (lobe_sign == lppa_pkg::LOBE_POS) begin
               if (s >= lobe_peak) lobe_peak = s;
            end else begin
               close_lobe();
               lobe_sign = lppa_pkg::LOBE_POS;
               lobe_peak = s;
            end
         end else if (s < 0) begin
            if (lobe_sign == lppa_pkg::LOBE_NEG) begin
               if (s <= lobe_peak) lobe_peak = s;
            end else begin
               close_lobe();
               lobe_sign = lppa_pkg::LOBE_NEG;
               lobe_peak = s;
            end
         end else begin
            close_lobe();
         end
         if (last) begin
            close_lobe();
            r.avg      = (pair_total != 0) ? lppa_pkg::AVG_W'(amp_sum / pair_total) : '0;
            r.pairs    = pair_total;
            r.overflow = overflow;
            expected_amplitudes.insert(expected_amplitudes.size(), r);
            clear_record();
         end
      endfunction

      function void note_mismatch(string msg);
         errors++;
         if (reported < MAX_REPORTS) begin
            reported++;
            $display("%t mismatch: %s", $realtime, msg);
         end
      endfunction

      // one accepted result against the oldest expectation
      function void check_amplitude(logic [lppa_pkg::AVG_W-1:0] avg,
                                    logic [lppa_pkg::PAIR_W-1:0] pairs, logic ovf);
         amp_result_type e;
         if (expected_amplitudes.size() == 0) begin
            note_mismatch($sformatf("unexpected result avg=%0d pairs=%0d ovf=%0b",
                                    avg, pairs, ovf));
         end else begin
            e = expected_amplitudes.pop_front();
            if (e.avg !== avg || e.pairs !== pairs || e.overflow !== ovf)
               note_mismatch($sformatf(
                  "expected avg=%0d pairs=%0d ovf=%0b, got avg=%0d pairs=%0d ovf=%0b",
                  e.avg, e.pairs, e.overflow, avg, pairs, ovf));
         end
      endfunction
   endclass

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            psel;
   logic                            penable;
   logic                            pwrite;
   logic [lppa_pkg::CSR_ADDR_W-1:0] paddr;
   logic [lppa_pkg::CSR_DATA_W-1:0] pwdata;
   logic [lppa_pkg::CSR_DATA_W-1:0] prdata;
   logic                            pready;

   lppa_req_if req_if();
   lppa_rsp_if rsp_if();

   lobe_amp_tracker board = new();

   int         send_idle_pct;
   int         rcv_idle_pct;
   bit         hold_request;
   sample_type record_q[$];

   lobe_peak_to_peak_amplitude dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always #HALF_PERIOD clock = ~clock;

   // run limit
   initial begin
      #10_000_000;
      $display("tb_top: FAIL");
      $finish;
   end

   // result receiver with random stalls and one long hold-off
   initial begin
      bit held;
      held         = 1'b0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !held) begin
            held = 1'b1;
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         board.check_amplitude(rsp_if.avg_amplitude, rsp_if.pairs_found,
                               rsp_if.queue_overflow);
   end

   // offer one item, return at the accepting edge
   task automatic send_sample(sample_type s, logic last);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid  <= 1'b1;
      req_if.sample <= s;
      req_if.last   <= last;
      do @(posedge clock); while (!req_if.ready);
      board.take_sample(s, last);
   endtask

   task automatic send_record(inout int count);
      for (int i = 0; i < record_q.size(); i++) begin
         send_sample(record_q[i], i == record_q.size() - 1);
         count++;
      end
   endtask

   // stop offering and wait until every expected result has come
   task automatic wait_idle();
      int n;
      n = 0;
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (board.expected_amplitudes.size() != 0 && n < DRAIN_LIMIT) begin
         @(negedge clock);
         n++;
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // apb write of the threshold, called at a falling edge
   task automatic write_threshold(logic [lppa_pkg::CSR_DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= lppa_pkg::CSR_ADDR_W'({lppa_pkg::REG_THRESH, 2'b00});
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      board.set_threshold(value);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   function automatic logic [lppa_pkg::CSR_DATA_W-1:0] pick_threshold();
      logic [lppa_pkg::CSR_DATA_W-1:0] value;
      value = $urandom();
      case ($urandom_range(7)) inside
         0:       value[lppa_pkg::THRESH_W-1:0] = '0;
         1:       value[lppa_pkg::THRESH_W-1:0] = '1;
         [2:3]:   value[lppa_pkg::THRESH_W-1:0] = lppa_pkg::THRESH_W'($urandom_range(200));
         [4:5]:   value[lppa_pkg::THRESH_W-1:0] = lppa_pkg::THRESH_W'($urandom_range(2000));
         default: value[lppa_pkg::THRESH_W-1:0] = lppa_pkg::THRESH_W'($urandom());
      endcase
      return value;
   endfunction

   // one lobe sample; keep forces a magnitude above the threshold where the sample range allows
   function automatic sample_type lobe_value(bit neg, bit keep);
      int limit;
      int mag;
      limit = neg ? 32768 : 32767;
      if (keep) begin
         mag = int'(board.threshold) + 1 + int'($urandom_range(200));
      end else begin
         case ($urandom_range(9)) inside
            [0:1]:   mag = int'(board.threshold) - 1 + int'($urandom_range(2));
            2:       mag = limit;
            [3:5]:   mag = int'($urandom_range(300, 1));
            default: mag = int'($urandom_range(limit, 1));
         endcase
      end
      if (mag < 1) mag = 1;
      if (mag > limit) mag = limit;
      return neg ? sample_type'(-mag) : sample_type'(mag);
   endfunction

   // append one sample to the record under construction
   function automatic void add_sample(sample_type s);
      record_q.insert(record_q.size(), s);
   endfunction

   // raw random samples
   function automatic void build_noise();
      int len;
      len = $urandom_range(16, 1);
      record_q.delete();
      repeat (len) add_sample(sample_type'($urandom()));
   endfunction

   // mostly alternating lobes, some zeros and merged lobes
   function automatic void build_wave();
      int  lobes;
      int  len;
      bit  neg;
      record_q.delete();
      neg   = $urandom_range(1);
      lobes = $urandom_range(8, 1);
      repeat (lobes) begin
         len = $urandom_range(4, 1);
         repeat (len) add_sample(lobe_value(neg, 1'b0));
         if ($urandom_range(4) == 0) add_sample('0);
         if ($urandom_range(5) != 0) neg = !neg;
      end
   endfunction

   // a run of same-sign lobes split by zeros, then a run of the other sign
   function automatic void build_runs(int first_count, int second_count, bit keep);
      bit neg;
      record_q.delete();
      neg = $urandom_range(1);
      repeat (first_count) begin
         repeat ($urandom_range(2, 1)) add_sample(lobe_value(neg, keep));
         add_sample('0);
      end
      repeat (second_count) begin
         repeat ($urandom_range(2, 1)) add_sample(lobe_value(!neg, keep));
         add_sample('0);
      end
      if ($urandom_range(1)) void'(record_q.pop_back());
   endfunction

   // stimulus
   initial begin
      int  items;
      int  rand_items;
      int  records;
      int  kind;
      bit  hold_done;
      req_if.valid  = 1'b0;
      req_if.sample = '0;
      req_if.last   = 1'b0;
      psel          = 1'b0;
      penable       = 1'b0;
      pwrite        = 1'b0;
      paddr         = '0;
      pwdata        = '0;
      reset         = 1'b1;
      hold_request  = 1'b0;
      hold_done     = 1'b0;
      send_idle_pct = 36;
      rcv_idle_pct  = 59;
      items         = 0;
      rand_items    = 0;
      records       = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: extremes, direct sign change, zero close, last closing an open lobe
      record_q = '{sample_type'(32767), sample_type'(100), sample_type'(-32768),
                   sample_type'(-5), sample_type'(0), sample_type'(1), sample_type'(-1)};
      send_record(items);
      // lone zero as last: no pairs
      record_q = '{sample_type'(0)};
      send_record(items);
      // minimum queued first, equal samples in a lobe
      record_q = '{sample_type'(-300), sample_type'(-200), sample_type'(5), sample_type'(5),
                   sample_type'(-1), sample_type'(-1)};
      send_record(items);
      record_q = '{sample_type'(1)};
      send_record(items);
      // largest threshold: only the most negative sample can count
      wait_idle();
      write_threshold(32'(32767));
      record_q = '{sample_type'(32767), sample_type'(-32768), sample_type'(32767),
                   sample_type'(-32767)};
      send_record(items);
      // peaks at the threshold are dropped, one above it kept
      wait_idle();
      write_threshold(32'(100));
      record_q = '{sample_type'(100), sample_type'(-101), sample_type'(101),
                   sample_type'(-100), sample_type'(200), sample_type'(-300)};
      send_record(items);

      // random records
      while (rand_items < RANDOM_ITEMS || records < MIN_RECORDS) begin
         if (rand_items >= 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct = 0;
            rcv_idle_pct  = 0;
         end else if (rand_items >= RANDOM_ITEMS / 3) begin
            send_idle_pct = 59;
            rcv_idle_pct  = 36;
            if (!hold_done) begin
               hold_request = 1'b1;
               hold_done    = 1'b1;
            end
         end
         if (records % RECORDS_PER_SETTING == RECORDS_PER_SETTING - 1) begin
            wait_idle();
            write_threshold(pick_threshold());
         end
         kind = $urandom_range(99);
         if (records == 0)
            build_runs(lppa_pkg::QUEUE_DEPTH + 4 + $urandom_range(3), $urandom_range(4, 1),
                       1'b1);
         else if (kind >= 97)
            build_runs(lppa_pkg::QUEUE_DEPTH + $urandom_range(4), $urandom_range(4, 1),
                       1'b0);
         else if (kind < 10)
            build_noise();
         else if (kind < 80)
            build_wave();
         else
            build_runs($urandom_range(10, 2), $urandom_range(10, 1), 1'b0);
         send_record(rand_items);
         records++;
      end

      wait_idle();
      if (board.errors == 0 && board.expected_amplitudes.size() == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/lppa_pkg.sv
rtl/core/lppa_req_if.sv
rtl/core/lppa_rsp_if.sv
rtl/core/lppa_ram.sv
rtl/core/lppa_div.sv
rtl/core/lobe_peak_to_peak_amplitude.sv
tb/tb_top.sv
